// ----- design/lcs_pkg.sv -----
// Shared types and constants for the LOOK / C-LOOK seek distance block.
package lcs_pkg;

  localparam int unsigned MAX_REQ_DEF  = 64;
  localparam int unsigned CYL_BITS_DEF = 16;

  localparam int unsigned CYL_FIELD_W = 16;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned CNT_FIELD_W = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_START_HEAD = 2'd1,
    CFG_PREV_HEAD  = 2'd2
  } lcs_cfg_reg_e;

  typedef struct packed {
    logic [CYL_FIELD_W-1:0] request_cylinder;
    logic                   last_request;
  } lcs_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]       total_movement;
    logic [CNT_FIELD_W-1:0] request_count;
    logic                   overflow;
  } lcs_res_t;

  // Sweep order selection handed to the sweep engine.
  typedef struct packed {
    logic up;
    logic clook;
  } lcs_sweep_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SWEEP_GO,
    ST_SWEEP_WAIT,
    ST_PUSH
  } lcs_top_state_e;

  typedef enum logic [1:0] {
    INS_IDLE,
    INS_RD,
    INS_CMP
  } lcs_ins_state_e;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_SCAN_RD,
    SW_SCAN_CMP,
    SW_RUN
  } lcs_swp_state_e;

endpackage

// ----- design/lcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/lcs_insert.sv -----
// Insertion engine: shifts larger entries up one place and writes the new request.
module lcs_insert #(
  parameter int unsigned MAX_REQUESTS  = 64,
  parameter int unsigned CYLINDER_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(MAX_REQUESTS)-1:0]  count_i,
  input  logic [CYLINDER_BITS-1:0]         cyl_i,
  input  logic [CYLINDER_BITS-1:0]         rdata_i,
  output logic [$clog2(MAX_REQUESTS)-1:0]  raddr_o,
  output logic                             we_o,
  output logic [$clog2(MAX_REQUESTS)-1:0]  waddr_o,
  output logic [CYLINDER_BITS-1:0]         wdata_o,
  output logic                             done_o
);

  import lcs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_REQUESTS);

  lcs_ins_state_e state_q, state_d;
  logic [AW-1:0]  pos_q, pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= INS_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    we_o    = 1'b0;
    waddr_o = pos_q;
    wdata_o = cyl_i;
    done_o  = 1'b0;
    unique case (state_q)
      INS_IDLE: begin
        if (start_i) begin
          pos_d   = count_i;
          state_d = INS_RD;
        end
      end
      INS_RD: begin
        if (pos_q == '0) begin
          we_o    = 1'b1;
          done_o  = 1'b1;
          state_d = INS_IDLE;
        end else begin
          state_d = INS_CMP;
        end
      end
      INS_CMP: begin
        we_o = 1'b1;
        if (rdata_i > cyl_i) begin
          // Move the larger entry up; the entry below it is already being read.
          wdata_o = rdata_i;
          pos_d   = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = INS_RD;
          end
        end else begin
          done_o  = 1'b1;
          state_d = INS_IDLE;
        end
      end
      default: state_d = INS_IDLE;
    endcase
  end

  // The entry just below the next insertion point is always the one to compare.
  assign raddr_o = pos_d - AW'(1);

endmodule

// ----- design/lcs_sweep.sv -----
// Sweep engine: finds the split point, then walks the sorted store summing head movement.
module lcs_sweep #(
  parameter int unsigned MAX_REQUESTS  = 64,
  parameter int unsigned CYLINDER_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  lcs_pkg::lcs_sweep_cmd_t           cmd_i,
  input  logic [$clog2(MAX_REQUESTS+1)-1:0] count_i,
  input  logic [CYLINDER_BITS-1:0]          head_i,
  input  logic [CYLINDER_BITS-1:0]          rdata_i,
  output logic [$clog2(MAX_REQUESTS)-1:0]   raddr_o,
  output logic                              done_o,
  output logic [lcs_pkg::SUM_W-1:0]         sum_o
);

  import lcs_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_REQUESTS);
  localparam int unsigned CW  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned ACW = ((CYLINDER_BITS > SUM_W) ? CYLINDER_BITS : SUM_W) + 1;

  lcs_swp_state_e      state_q, state_d;
  lcs_sweep_cmd_t      cmd_q, cmd_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic                asc_q, asc_d;
  logic                second_q, second_d;
  logic [CW-1:0]       seg2_idx_q, seg2_idx_d;
  logic [CW-1:0]       seg2_len_q, seg2_len_d;
  logic                seg2_asc_q, seg2_asc_d;
  logic                pend_q, pend_d;
  logic [CYLINDER_BITS-1:0] cur_q, cur_d;
  logic [SUM_W-1:0]    sum_q, sum_d;

  logic                scan_end;
  logic [CW-1:0]       split;
  logic [CW-1:0]       above;
  logic [CYLINDER_BITS-1:0] step_len;
  logic [ACW-1:0]      acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SW_IDLE;
      cmd_q      <= '0;
      n_q        <= '0;
      idx_q      <= '0;
      rem_q      <= '0;
      asc_q      <= 1'b0;
      second_q   <= 1'b0;
      seg2_idx_q <= '0;
      seg2_len_q <= '0;
      seg2_asc_q <= 1'b0;
      pend_q     <= 1'b0;
      cur_q      <= '0;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      n_q        <= n_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      asc_q      <= asc_d;
      second_q   <= second_d;
      seg2_idx_q <= seg2_idx_d;
      seg2_len_q <= seg2_len_d;
      seg2_asc_q <= seg2_asc_d;
      pend_q     <= pend_d;
      cur_q      <= cur_d;
      sum_q      <= sum_d;
    end
  end

  // Movement towards the entry whose read data arrives this cycle.
  assign step_len = (rdata_i > cur_q) ? (rdata_i - cur_q) : (cur_q - rdata_i);
  assign acc      = ACW'(sum_q) + ACW'(step_len);
  assign above    = n_q - split;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    n_d        = n_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    asc_d      = asc_q;
    second_d   = second_q;
    seg2_idx_d = seg2_idx_q;
    seg2_len_d = seg2_len_q;
    seg2_asc_d = seg2_asc_q;
    pend_d     = 1'b0;
    cur_d      = cur_q;
    sum_d      = sum_q;
    done_o     = 1'b0;
    scan_end   = 1'b0;
    split      = idx_q;

    if (pend_q) begin
      cur_d = rdata_i;
      sum_d = (acc > ACW'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
    end

    unique case (state_q)
      SW_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          n_d     = count_i;
          idx_d   = '0;
          cur_d   = head_i;
          sum_d   = '0;
          state_d = SW_SCAN_RD;
        end
      end
      SW_SCAN_RD: begin
        if (idx_q == n_q) begin
          scan_end = 1'b1;
        end else begin
          state_d = SW_SCAN_CMP;
        end
      end
      SW_SCAN_CMP: begin
        // The first entry at or above the head splits the store.
        if (rdata_i >= cur_q) begin
          scan_end = 1'b1;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = SW_SCAN_RD;
        end
      end
      SW_RUN: begin
        if (rem_q != '0) begin
          pend_d = 1'b1;
          rem_d  = rem_q - CW'(1);
          idx_d  = asc_q ? (idx_q + CW'(1)) : (idx_q - CW'(1));
        end else if (!second_q) begin
          second_d = 1'b1;
          idx_d    = seg2_idx_q;
          rem_d    = seg2_len_q;
          asc_d    = seg2_asc_q;
        end else if (!pend_q) begin
          done_o  = 1'b1;
          state_d = SW_IDLE;
        end
      end
      default: state_d = SW_IDLE;
    endcase

    if (scan_end) begin
      state_d  = SW_RUN;
      second_d = 1'b0;
      if (cmd_q.up) begin
        idx_d = split;
        rem_d = above;
        asc_d = 1'b1;
        seg2_len_d = split;
        if (cmd_q.clook) begin
          seg2_idx_d = '0;
          seg2_asc_d = 1'b1;
        end else begin
          seg2_idx_d = split - CW'(1);
          seg2_asc_d = 1'b0;
        end
      end else begin
        idx_d = split - CW'(1);
        rem_d = split;
        asc_d = 1'b0;
        seg2_len_d = above;
        if (cmd_q.clook) begin
          seg2_idx_d = n_q - CW'(1);
          seg2_asc_d = 1'b0;
        end else begin
          seg2_idx_d = split;
          seg2_asc_d = 1'b1;
        end
      end
    end
  end

  assign raddr_o = idx_q[AW-1:0];
  assign sum_o   = sum_q;

endmodule

// ----- design/look_clook_seek_distance.sv -----
// Top level: request intake, batch control, shared request store and result register.
// A stored request stalls the input while it is inserted, longer the more stored entries are
// larger than it; the single read port sets this. After a last request the input stays
// stalled while the sweep scans the entries below the start head and walks the store, and
// until its result transfer is offered once the result register is free.
// Reset clears all control state and configuration registers; the store is not cleared.
module look_clook_seek_distance #(
  parameter int unsigned MAX_REQUESTS  = lcs_pkg::MAX_REQ_DEF,
  parameter int unsigned CYLINDER_BITS = lcs_pkg::CYL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lcs_pkg::lcs_req_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lcs_pkg::lcs_res_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import lcs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_REQUESTS);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);

  lcs_top_state_e state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic           drop_q, drop_d;
  logic           last_q, last_d;
  logic [CYLINDER_BITS-1:0] cyl_q, cyl_d;

  logic                   mode_q;
  logic [CFG_DATA_W-1:0]  start_head_q;
  logic [CFG_DATA_W-1:0]  prev_head_q;

  logic     out_valid_q, out_valid_d;
  lcs_res_t out_data_q, out_data_d;

  logic                  in_xfer;
  logic                  full;
  logic [CYLINDER_BITS+CYL_FIELD_W-1:0] cyl_ext;
  logic [CYLINDER_BITS+CFG_DATA_W-1:0]  head_ext;
  logic [CW+CNT_FIELD_W-1:0]            cnt_ext;

  logic                     ins_start;
  logic                     ins_done;
  logic [AW-1:0]            ins_raddr;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [CYLINDER_BITS-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [CYLINDER_BITS-1:0] ram_rdata;

  logic                     swp_start;
  logic                     swp_done;
  lcs_sweep_cmd_t           swp_cmd;
  logic [AW-1:0]            swp_raddr;
  logic [SUM_W-1:0]         swp_sum;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      start_head_q <= '0;
      prev_head_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:       mode_q       <= cfg_data_i[0];
        CFG_START_HEAD: start_head_q <= cfg_data_i;
        CFG_PREV_HEAD:  prev_head_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cyl_q      <= cyl_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(MAX_REQUESTS));

  assign cyl_ext  = {{CYLINDER_BITS{1'b0}}, in_data_i.request_cylinder};
  assign head_ext = {{CYLINDER_BITS{1'b0}}, start_head_q};
  assign cnt_ext  = {{CNT_FIELD_W{1'b0}}, count_q};

  assign swp_cmd.up    = !(prev_head_q > start_head_q);
  assign swp_cmd.clook = mode_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    last_d      = last_q;
    cyl_d       = cyl_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ins_start   = 1'b0;
    swp_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cyl_d  = cyl_ext[CYLINDER_BITS-1:0];
          last_d = in_data_i.last_request;
          if (full) begin
            // A full store drops the request, but a last mark still closes the batch.
            drop_d = 1'b1;
            if (in_data_i.last_request) begin
              state_d = ST_SWEEP_GO;
            end
          end else begin
            ins_start = 1'b1;
            state_d   = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (ins_done) begin
          count_d = count_q + CW'(1);
          state_d = last_q ? ST_SWEEP_GO : ST_IDLE;
        end
      end
      ST_SWEEP_GO: begin
        swp_start = 1'b1;
        state_d   = ST_SWEEP_WAIT;
      end
      ST_SWEEP_WAIT: begin
        if (swp_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_data_d.total_movement = swp_sum;
          out_data_d.request_count  = cnt_ext[CNT_FIELD_W-1:0];
          out_data_d.overflow       = drop_q;
          count_d                    = '0;
          drop_d                     = 1'b0;
          state_d                    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ram_raddr = (state_q == ST_INSERT) ? ins_raddr : swp_raddr;

  lcs_ram #(
    .WIDTH (CYLINDER_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lcs_insert #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_insert (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ins_start),
    .count_i (count_q[AW-1:0]),
    .cyl_i   (cyl_q),
    .rdata_i (ram_rdata),
    .raddr_o (ins_raddr),
    .we_o    (ram_we),
    .waddr_o (ram_waddr),
    .wdata_o (ram_wdata),
    .done_o  (ins_done)
  );

  lcs_sweep #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (swp_start),
    .cmd_i   (swp_cmd),
    .count_i (count_q),
    .head_i  (head_ext[CYLINDER_BITS-1:0]),
    .rdata_i (ram_rdata),
    .raddr_o (swp_raddr),
    .done_o  (swp_done),
    .sum_o   (swp_sum)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
